@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each use sits inside a module that has
// clk and rst_n; checks are disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define AFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AFC_ASSERT_IMP(lbl, ante, cons, msg)
`define AFC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/afc_pkg.sv @@
package afc_pkg;

  localparam int unsigned PLANE_COUNT_DEF = 6;

  localparam int unsigned IDX_W   = 3;
  localparam int unsigned NORM_W  = 16;
  localparam int unsigned OFF_W   = 32;
  localparam int unsigned CTR_W   = 32;
  localparam int unsigned EXT_W   = 31;
  // Doubled corner coordinate: 2*center +/- extent.
  localparam int unsigned VERT_W  = 34;
  localparam int unsigned PROD_W  = NORM_W + VERT_W;
  // Three products plus the scaled offset stay well below 2^51 in magnitude.
  localparam int unsigned SUM_W   = 52;
  // Offset is doubled and brought to the Q1.14 normal scale.
  localparam int unsigned OFF_SHIFT = 15;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_TEST  = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic [IDX_W-1:0]          plane_index;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic signed [OFF_W-1:0]   plane_offset;
    logic signed [CTR_W-1:0]   center_x;
    logic signed [CTR_W-1:0]   center_y;
    logic signed [CTR_W-1:0]   center_z;
    logic [EXT_W-1:0]          extent_x;
    logic [EXT_W-1:0]          extent_y;
    logic [EXT_W-1:0]          extent_z;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
  } out_item_t;

  // An item moving along the chain, with the running reject flag.
  typedef struct packed {
    in_item_t item;
    logic     culled;
  } afc_work_t;

  // Doubled coordinate of the box corner that lies farthest along the normal.
  function automatic logic signed [VERT_W-1:0] pos_vertex(
    input logic signed [NORM_W-1:0] n,
    input logic signed [CTR_W-1:0]  c,
    input logic [EXT_W-1:0]         e
  );
    logic signed [VERT_W-1:0] c2;
    logic signed [VERT_W-1:0] ev;
    c2 = {{(VERT_W-CTR_W-1){c[CTR_W-1]}}, c, 1'b0};
    ev = {{(VERT_W-EXT_W){1'b0}}, e};
    return n[NORM_W-1] ? (c2 - ev) : (c2 + ev);
  endfunction

endpackage

@@ rtl/afc_stream_if.sv @@
interface afc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/afc_cell.sv @@
module afc_cell import afc_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  afc_work_t up_work,
  output logic      dn_valid,
  input  logic      dn_ready,
  output afc_work_t dn_work
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  // Plane held by this cell.
  logic signed [NORM_W-1:0] nx_r, ny_r, nz_r;
  logic signed [OFF_W-1:0]  d_r;

  // Stage 1: products of the normal and the positive vertex.
  logic                     s1_v_r;
  afc_work_t                s1_work_r;
  logic signed [PROD_W-1:0] s1_px_r, s1_py_r, s1_pz_r;
  logic signed [SUM_W-1:0]  s1_off_r;

  // Stage 2: plane decision folded into the running flag.
  logic      s2_v_r;
  afc_work_t s2_work_r;

  logic                     s1_en, s2_en, wr_hit;
  logic signed [VERT_W-1:0] vx, vy, vz;
  logic signed [PROD_W-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [SUM_W-1:0]  off_nxt, sum;
  afc_work_t                s2_work_nxt;

  assign s2_en    = !s2_v_r || dn_ready;
  assign s1_en    = !s1_v_r || s2_en;
  assign up_ready = s1_en;
  assign dn_valid = s2_v_r;
  assign dn_work  = s2_work_r;

  assign wr_hit = up_valid && s1_en && (up_work.item.mode == MODE_WRITE) &&
                  (up_work.item.plane_index == MY_IDX);

  assign vx = pos_vertex(nx_r, up_work.item.center_x, up_work.item.extent_x);
  assign vy = pos_vertex(ny_r, up_work.item.center_y, up_work.item.extent_y);
  assign vz = pos_vertex(nz_r, up_work.item.center_z, up_work.item.extent_z);

  assign px_nxt  = PROD_W'(nx_r) * PROD_W'(vx);
  assign py_nxt  = PROD_W'(ny_r) * PROD_W'(vy);
  assign pz_nxt  = PROD_W'(nz_r) * PROD_W'(vz);
  assign off_nxt = SUM_W'(d_r) <<< OFF_SHIFT;

  assign sum = SUM_W'(s1_px_r) + SUM_W'(s1_py_r) + SUM_W'(s1_pz_r) + s1_off_r;

  always_comb begin
    s2_work_nxt = s1_work_r;
    if (s1_work_r.item.mode == MODE_TEST && sum[SUM_W-1]) begin
      s2_work_nxt.culled = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= '0;
      ny_r <= '0;
      nz_r <= '0;
      d_r  <= '0;
    end else if (wr_hit) begin
      nx_r <= up_work.item.normal_x;
      ny_r <= up_work.item.normal_y;
      nz_r <= up_work.item.normal_z;
      d_r  <= up_work.item.plane_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= up_valid;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_work_r <= up_work;
      s1_px_r   <= px_nxt;
      s1_py_r   <= py_nxt;
      s1_pz_r   <= pz_nxt;
      s1_off_r  <= off_nxt;
    end
    if (s2_en) begin
      s2_work_r <= s2_work_nxt;
    end
  end

endmodule

@@ rtl/aabb_frustum_cull.sv @@
// Box-versus-frustum culling with a table of PLANE_COUNT planes.
// The input channel in_if carries one transaction per item. A transaction
// with mode write loads plane plane_index with its normal and offset; an
// index at or above PLANE_COUNT is dropped. A transaction with mode test
// carries a box center and full size and yields one transaction on out_if,
// whose inside_res is 1 when no plane has the box's positive vertex behind it.
// Write transactions produce no output.
// Each plane lives in one cell of a chain; every cell has a multiply stage and
// a sum stage, followed at the end by one output register, which presents the
// test result on out_if. The chain takes one transaction per cycle, limited
// only by the handshake; writes and tests keep their order, so a test sees
// exactly the writes that came before it.
// Reset clears every plane to a zero normal and zero offset, which rejects
// nothing, and empties the chain.
// When the receiver stalls, the result stays in the output register and the
// chain keeps taking transactions until its stages fill up behind it.
`include "assert_macros.svh"

module aabb_frustum_cull import afc_pkg::*; #(
  parameter int unsigned PLANE_COUNT = PLANE_COUNT_DEF
) (
  input logic            clk,
  input logic            rst_n,
  afc_stream_if.sink     in_if,
  afc_stream_if.source   out_if
);

  // Link k feeds cell k; the last link feeds the output register.
  logic      link_v   [PLANE_COUNT+1];
  logic      link_rdy [PLANE_COUNT+1];
  afc_work_t link_w   [PLANE_COUNT+1];

  logic out_valid_r, out_valid_nxt;
  logic out_inside_r;
  logic last_fire;
  logic last_test;
  logic last_inside;

  assign link_v[0]      = in_if.valid;
  assign link_w[0].item = in_if.payload;
  assign link_w[0].culled = 1'b0;
  assign in_if.ready    = link_rdy[0];

  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
    afc_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_v[k]),
      .up_ready (link_rdy[k]),
      .up_work  (link_w[k]),
      .dn_valid (link_v[k+1]),
      .dn_ready (link_rdy[k+1]),
      .dn_work  (link_w[k+1])
    );
  end

  // The output register drops write transactions and keeps test results.
  assign link_rdy[PLANE_COUNT] = !out_valid_r || out_if.ready;
  assign last_fire   = link_v[PLANE_COUNT] && link_rdy[PLANE_COUNT];
  assign last_test   = last_fire && (link_w[PLANE_COUNT].item.mode == MODE_TEST);
  assign last_inside = !link_w[PLANE_COUNT].culled;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (last_test) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (last_test) begin
      out_inside_r <= last_inside;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.payload.inside_res = out_inside_r;

  // Right after reset the chain is empty and must take a transaction.
  `AFC_ASSERT_IMP(a_ready_after_reset, !$past(rst_n), in_if.ready, "chain not ready after reset")
  // A write leaving the chain while the receiver takes data leaves no result.
  `AFC_ASSERT_NXT(a_wr_silent, last_fire && !last_test && out_if.ready, !out_valid_r, "stray result")
  // A test leaving the chain always shows up in the output register.
  `AFC_ASSERT_NXT(a_test_valid, last_test, out_valid_r, "test result lost")
  // The result carries the inverse of the test's reject flag.
  `AFC_ASSERT_NXT(a_test_value, last_test, out_inside_r == $past(last_inside), "wrong verdict")

endmodule
